@@ rtl/core/assert_macros.svh @@
// Assertion helper macros for the checker in mcc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/mcc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcc_pkg
// Types, constants and command codes of the Collatz memo cache.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int NUMBER_BITS  = 20;
    localparam int STEP_BITS    = 10;
    localparam int PICK_BITS    = 16;
    localparam int USES_BITS    = 16;
    localparam int TRAJ_BITS    = 64;

    localparam int CFG_POL_W  = 3;
    localparam int CFG_CAP_W  = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

    localparam logic [CFG_POL_W-1:0] POL_LRU    = 3'd0;
    localparam logic [CFG_POL_W-1:0] POL_FIFO   = 3'd1;
    localparam logic [CFG_POL_W-1:0] POL_LFU    = 3'd2;
    localparam logic [CFG_POL_W-1:0] POL_MRU    = 3'd3;
    localparam logic [CFG_POL_W-1:0] POL_RANDOM = 3'd4;

    localparam logic [CFG_CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};
    localparam logic [USES_BITS-1:0] USES_MAX = {USES_BITS{1'b1}};
    // largest trajectory value for which 3n+1 still fits
    localparam logic [TRAJ_BITS-1:0] TRAJ_LIM = 64'h5555_5555_5555_5554;

    typedef struct packed {
        logic [NUMBER_BITS-1:0] number;
        logic [PICK_BITS-1:0]   random_pick;
    } t_in_item;

    typedef struct packed {
        logic [STEP_BITS-1:0] step_count;
        logic                 hit;
    } t_out_item;

    typedef struct packed {
        logic [NUMBER_BITS-1:0] key;
        logic [STEP_BITS-1:0]   result;
        logic [USES_BITS-1:0]   uses;
    } t_entry;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN_RD,
        CMD_SCAN_NEXT,
        CMD_HIT,
        CMD_WR_POS,
        CMD_COL_INIT,
        CMD_COL_STEP,
        CMD_INS_INIT,
        CMD_LFU_INIT,
        CMD_LFU_RD,
        CMD_LFU_CMP,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_VIC_HEAD,
        CMD_VIC_TAIL,
        CMD_VIC_MIN,
        CMD_VIC_REM,
        CMD_UP_RD,
        CMD_UP_WR,
        CMD_REMOVE,
        CMD_DN_RD,
        CMD_DN_WR,
        CMD_WR_HEAD,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic                 scan_end;
        logic                 match;
        logic                 col_done;
        logic                 full;
        logic                 div_done;
        logic                 up_end;
        logic                 dn_end;
        logic                 out_free;
        logic [CFG_POL_W-1:0] policy;
    } t_status;

endpackage

@@ rtl/core/mcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcc_ctrl
// Sequencer: steps the datapath through scan, update, compute, evict, insert.
// ----------------------------------------------------------------------------
module mcc_ctrl import mcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_WR_POS, S_COL, S_EVICT, S_LFU_RD,
        S_LFU_CMP, S_DIV, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;
    t_cmd   n_cmd;

    // next state and command
    always_comb begin
        n_state = r_state;
        n_cmd   = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = CMD_LOAD;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_status.scan_end) begin
                    n_cmd   = CMD_COL_INIT;
                    n_state = S_COL;
                end else begin
                    n_cmd   = CMD_SCAN_RD;
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_status.match) begin
                    n_cmd = CMD_HIT;
                    if (i_status.policy == POL_LRU || i_status.policy == POL_MRU)
                        n_state = S_DN_RD;
                    else
                        n_state = S_WR_POS;
                end else begin
                    n_cmd   = CMD_SCAN_NEXT;
                    n_state = S_SCAN_RD;
                end
            end
            S_WR_POS: begin
                n_cmd   = CMD_WR_POS;
                n_state = S_DONE;
            end
            S_COL: begin
                if (i_status.col_done) n_state = S_EVICT;
                else n_cmd = CMD_COL_STEP;
            end
            S_EVICT: begin
                if (!i_status.full) begin
                    n_cmd   = CMD_INS_INIT;
                    n_state = S_DN_RD;
                end else begin
                    case (i_status.policy)
                        POL_LFU: begin
                            n_cmd   = CMD_LFU_INIT;
                            n_state = S_LFU_RD;
                        end
                        POL_MRU: begin
                            n_cmd   = CMD_VIC_HEAD;
                            n_state = S_UP_RD;
                        end
                        POL_RANDOM: begin
                            n_cmd   = CMD_DIV_INIT;
                            n_state = S_DIV;
                        end
                        default: begin
                            n_cmd   = CMD_VIC_TAIL;
                            n_state = S_UP_RD;
                        end
                    endcase
                end
            end
            S_LFU_RD: begin
                if (i_status.scan_end) begin
                    n_cmd   = CMD_VIC_MIN;
                    n_state = S_UP_RD;
                end else begin
                    n_cmd   = CMD_LFU_RD;
                    n_state = S_LFU_CMP;
                end
            end
            S_LFU_CMP: begin
                n_cmd   = CMD_LFU_CMP;
                n_state = S_LFU_RD;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_cmd   = CMD_VIC_REM;
                    n_state = S_UP_RD;
                end else begin
                    n_cmd = CMD_DIV_STEP;
                end
            end
            S_UP_RD: begin
                if (i_status.up_end) begin
                    n_cmd   = CMD_REMOVE;
                    n_state = S_EVICT;
                end else begin
                    n_cmd   = CMD_UP_RD;
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                n_cmd   = CMD_UP_WR;
                n_state = S_UP_RD;
            end
            S_DN_RD: begin
                if (i_status.dn_end) begin
                    n_cmd   = CMD_WR_HEAD;
                    n_state = S_DONE;
                end else begin
                    n_cmd   = CMD_DN_RD;
                    n_state = S_DN_WR;
                end
            end
            S_DN_WR: begin
                n_cmd   = CMD_DN_WR;
                n_state = S_DN_RD;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_cmd   = CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_cmd      = n_cmd;
    assign o_in_stall = r_in_stall;

endmodule

@@ rtl/core/mcc_dpath.sv @@
// ----------------------------------------------------------------------------
// mcc_dpath
// Entry memory, scan/shift index, Collatz iterator, pick divider, output reg.
// ----------------------------------------------------------------------------
module mcc_dpath import mcc_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > CFG_CAP_W) ? CW : CFG_CAP_W;
    localparam int DCW   = $clog2(PICK_BITS + 1);

    t_entry mem [CAPACITY];
    t_entry r_rd, r_ent;

    logic [CFG_POL_W-1:0]   r_policy;
    logic [CFG_CAP_W-1:0]   r_capacity;
    logic [CW-1:0]          r_count, r_idx, r_victim, r_rem;
    logic [NUMBER_BITS-1:0] r_key;
    logic [PICK_BITS-1:0]   r_pick;
    logic [PICK_BITS-1:0]   r_dsh;
    logic [TRAJ_BITS-1:0]   r_n;
    logic [STEP_BITS-1:0]   r_steps;
    logic                   r_hit;
    logic [USES_BITS:0]     r_min;
    logic [DCW-1:0]         r_dcnt;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   rd_en, wr_en;
    logic [IW-1:0]          rd_addr, wr_addr;
    t_entry                 wr_data;
    logic [CMP_W-1:0]       cap_raw, cap_eff;
    logic [CW:0]            div_t;
    logic [CW:0]            idx_p1;

    // effective capacity: zero acts as one, clamp at CAPACITY
    always_comb begin
        cap_raw = CMP_W'(r_capacity);
        if (cap_raw == '0) cap_eff = CMP_W'(1);
        else if (cap_raw > CMP_W'(CAPACITY)) cap_eff = CMP_W'(CAPACITY);
        else cap_eff = cap_raw;
    end

    assign idx_p1 = {1'b0, r_idx} + (CW+1)'(1);
    // pick is kept intact; the divider shifts its own copy
    assign div_t  = {r_rem, r_dsh[PICK_BITS-1]};

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[IW-1:0];
        wr_data = r_rd;
        case (i_cmd)
            CMD_SCAN_RD, CMD_LFU_RD: rd_en = 1'b1;
            CMD_UP_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_p1[IW-1:0];
            end
            CMD_DN_RD: begin
                rd_en   = 1'b1;
                rd_addr = IW'(r_idx - CW'(1));
            end
            CMD_UP_WR, CMD_DN_WR: wr_en = 1'b1;
            CMD_WR_POS: begin
                wr_en   = 1'b1;
                wr_data = r_ent;
            end
            CMD_WR_HEAD: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_ent;
            end
            default: ;
        endcase
    end

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= POL_LRU;
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_POLICY) r_policy <= i_cfg_data[CFG_POL_W-1:0];
            if (i_cfg_idx == REG_CAPACITY) r_capacity <= i_cfg_data[CFG_CAP_W-1:0];
        end
    end

    // control registers: count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == CMD_REMOVE) r_count <= r_count - CW'(1);
            else if (i_cmd == CMD_WR_HEAD && !r_hit) r_count <= r_count + CW'(1);
            if (i_cmd == CMD_OUT) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_key <= i_in_item.number;
                r_pick <= i_in_item.random_pick;
                r_idx <= '0;
            end
            CMD_SCAN_NEXT: r_idx <= r_idx + CW'(1);
            CMD_HIT: begin
                r_ent.key <= r_rd.key;
                r_ent.result <= r_rd.result;
                r_ent.uses <= (r_rd.uses != USES_MAX) ? r_rd.uses + USES_BITS'(1)
                                                      : r_rd.uses;
                r_steps <= r_rd.result;
                r_hit <= 1'b1;
            end
            CMD_COL_INIT: begin
                r_n <= TRAJ_BITS'(r_key);
                r_steps <= '0;
                r_hit <= 1'b0;
            end
            CMD_COL_STEP: begin
                if (!r_n[0]) begin
                    r_n <= r_n >> 1;
                    r_steps <= r_steps + STEP_BITS'(1);
                end else if (r_n > TRAJ_LIM) begin
                    r_steps <= STEP_MAX;
                end else begin
                    r_n <= (r_n << 1) + r_n + TRAJ_BITS'(1);
                    r_steps <= r_steps + STEP_BITS'(1);
                end
            end
            CMD_INS_INIT: begin
                r_ent.key <= r_key;
                r_ent.result <= r_steps;
                r_ent.uses <= USES_BITS'(1);
                r_idx <= r_count;
            end
            CMD_LFU_INIT: begin
                r_idx <= '0;
                r_victim <= '0;
                r_min <= {1'b1, {USES_BITS{1'b0}}};
            end
            CMD_LFU_CMP: begin
                if ({1'b0, r_rd.uses} < r_min) begin
                    r_min <= {1'b0, r_rd.uses};
                    r_victim <= r_idx;
                end
                r_idx <= r_idx + CW'(1);
            end
            CMD_DIV_INIT: begin
                r_rem <= '0;
                r_dcnt <= '0;
                r_dsh <= r_pick;
            end
            CMD_DIV_STEP: begin
                if (div_t >= {1'b0, r_count}) r_rem <= CW'(div_t - {1'b0, r_count});
                else r_rem <= CW'(div_t);
                r_dsh <= r_dsh << 1;
                r_dcnt <= r_dcnt + DCW'(1);
            end
            CMD_VIC_HEAD: r_idx <= '0;
            CMD_VIC_TAIL: r_idx <= r_count - CW'(1);
            CMD_VIC_MIN: r_idx <= r_victim;
            CMD_VIC_REM: r_idx <= r_rem;
            CMD_UP_WR: r_idx <= r_idx + CW'(1);
            CMD_DN_WR: r_idx <= r_idx - CW'(1);
            CMD_OUT: begin
                r_out.step_count <= r_steps;
                r_out.hit <= r_hit;
            end
            default: ;
        endcase
    end

    // status to the sequencer
    always_comb begin
        o_status.scan_end = (r_idx >= r_count);
        o_status.match    = (r_rd.key == r_key);
        o_status.col_done = (r_n == TRAJ_BITS'(1)) || (r_steps == STEP_MAX);
        o_status.full     = (CMP_W'(r_count) >= cap_eff);
        o_status.div_done = (r_dcnt == DCW'(PICK_BITS));
        o_status.up_end   = (idx_p1 >= {1'b0, r_count});
        o_status.dn_end   = (r_idx == '0);
        o_status.out_free = !r_out_valid || !i_out_stall;
        o_status.policy   = r_policy;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ rtl/core/memo_collatz_cache.sv @@
// A hit scans from the head to its position; LRU and MRU then move it to the head;
// a miss adds the Collatz iteration (saturating at 1023 steps), any eviction sweeps
// and the insert shift; a random eviction also runs the pick divider.
// One transaction at a time: input stalls from acceptance until the result loads
// into the output register.
// Synchronous active-low reset empties the store and sets policy LRU, capacity 16.
// ----------------------------------------------------------------------------
// memo_collatz_cache
// Memo store of Collatz step counts with selectable replacement policy.
// ----------------------------------------------------------------------------
module memo_collatz_cache import mcc_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    mcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath
    mcc_dpath #(.CAPACITY(CAPACITY)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

@@ rtl/core/mcc_checker.sv @@
// ----------------------------------------------------------------------------
// mcc_checker
// Port-level checks on the memo cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcc_checker import mcc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_item              i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_item,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // reset leaves no result pending
    `ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    // one transaction at a time: input closes right after an accept
    `ASSERT_CLK(a_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input not closed while busy")
    // a stalled result stays
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid, "result dropped under stall")
    // a stalled result keeps its payload
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> $stable(o_out_item), "result changed under stall")

endmodule

bind memo_collatz_cache mcc_checker u_mcc_checker (.*);

@@ bench/memo_collatz_checker.sv @@
// ----------------------------------------------------------------------------
// memo_collatz_checker
// Watches both channels and the register port of the Collatz memo cache,
// keeps its own copy of the ordered store, predicts each result and
// compares every accepted output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module memo_collatz_checker import mcc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_hits,
    output int                    o_misses
);

    localparam int DEPTH = CAPACITY_DEF;

    logic [CFG_POL_W-1:0]   cur_policy;
    logic [CFG_CAP_W-1:0]   cur_capacity;
    logic [NUMBER_BITS-1:0] store_key   [DEPTH];
    logic [STEP_BITS-1:0]   store_steps [DEPTH];
    logic [USES_BITS-1:0]   store_uses  [DEPTH];
    int                     store_count;
    t_out_item              expected_results[$];

    // Collatz step count, saturating at STEP_MAX or on trajectory overflow
    function automatic logic [STEP_BITS-1:0] traj_steps(logic [NUMBER_BITS-1:0] num);
        logic [TRAJ_BITS-1:0] n;
        int                   steps;
        n = TRAJ_BITS'(num);
        steps = 0;
        while (n != 1 && steps < int'(STEP_MAX)) begin
            if (!n[0]) begin
                n = n >> 1;
            end else begin
                if (n > TRAJ_LIM) return STEP_MAX;
                n = 3 * n + 1;
            end
            steps++;
        end
        return STEP_BITS'(steps);
    endfunction

    // drop entry at pos, closing the gap
    task automatic drop_entry(int pos);
        for (int i = pos; i + 1 < store_count; i++) begin
            store_key[i]   = store_key[i+1];
            store_steps[i] = store_steps[i+1];
            store_uses[i]  = store_uses[i+1];
        end
        store_count--;
    endtask

    // move entry at pos to the head
    task automatic move_to_head(int pos);
        logic [NUMBER_BITS-1:0] k;
        logic [STEP_BITS-1:0]   r;
        logic [USES_BITS-1:0]   u;
        k = store_key[pos];
        r = store_steps[pos];
        u = store_uses[pos];
        for (int i = pos; i > 0; i--) begin
            store_key[i]   = store_key[i-1];
            store_steps[i] = store_steps[i-1];
            store_uses[i]  = store_uses[i-1];
        end
        store_key[0]   = k;
        store_steps[0] = r;
        store_uses[0]  = u;
    endtask

    // pick and remove one victim under the current policy
    task automatic evict_victim(logic [PICK_BITS-1:0] pick);
        int victim;
        victim = store_count - 1;
        case (cur_policy)
            POL_LFU: begin
                victim = 0;
                for (int i = 1; i < store_count; i++)
                    if (store_uses[i] < store_uses[victim]) victim = i;
            end
            POL_MRU:    victim = 0;
            POL_RANDOM: victim = int'(pick) % store_count;
            default:    victim = store_count - 1;
        endcase
        drop_entry(victim);
    endtask

    // look up one number, update the store and queue the expected result
    task automatic predict_lookup(t_in_item item);
        t_out_item res;
        int        cap;
        bit        found;
        found = 0;
        cap = int'(cur_capacity);
        if (cap == 0) cap = 1;
        if (cap > DEPTH) cap = DEPTH;
        for (int i = 0; i < store_count && !found; i++) begin
            if (store_key[i] == item.number) begin
                found = 1;
                res.step_count = store_steps[i];
                res.hit = 1'b1;
                if (store_uses[i] != USES_MAX) store_uses[i]++;
                if (cur_policy == POL_LRU || cur_policy == POL_MRU) move_to_head(i);
            end
        end
        if (!found) begin
            res.step_count = traj_steps(item.number);
            res.hit = 1'b0;
            while (store_count >= cap) evict_victim(item.random_pick);
            store_key[store_count]   = item.number;
            store_steps[store_count] = res.step_count;
            store_uses[store_count]  = 1;
            store_count++;
            move_to_head(store_count - 1);
        end
        expected_results.push_back(res);
    endtask

    // observe transactions at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_policy   <= POL_LRU;
            cur_capacity <= CAP_RESET;
            store_count  = 0;
            expected_results.delete();
            o_errors <= 0;
            o_hits   <= 0;
            o_misses <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_POLICY) cur_policy <= i_cfg_data[CFG_POL_W-1:0];
                else if (i_cfg_idx == REG_CAPACITY) cur_capacity <= i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) predict_lookup(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result step_count=%0d hit=%0d",
                             $time, i_out_item.step_count, i_out_item.hit);
                    o_errors <= o_errors + 1;
                end else begin
                    t_out_item want;
                    want = expected_results.pop_front();
                    if (want.step_count !== i_out_item.step_count
                        || want.hit !== i_out_item.hit) begin
                        $display("%0t: mismatch expected step_count=%0d hit=%0d, got %0d %0d",
                                 $time, want.step_count, want.hit,
                                 i_out_item.step_count, i_out_item.hit);
                        o_errors <= o_errors + 1;
                    end
                    if (want.hit) o_hits <= o_hits + 1;
                    else o_misses <= o_misses + 1;
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

@@ bench/tb_memo_collatz_cache.sv @@
// ----------------------------------------------------------------------------
// tb_memo_collatz_cache
// Drives the Collatz memo cache through directed and random lookups under
// every replacement policy and several capacities, with bursty input,
// random output stalls and a long output hold-off; verdict from the checker.
// ----------------------------------------------------------------------------
module tb_memo_collatz_cache;
    import mcc_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    hits;
    int                    misses;
    bit                    hold_off;
    int                    sent;

    memo_collatz_cache dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    memo_collatz_checker checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_hits     (hits),
        .o_misses   (misses)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int run;
        out_stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_stall <= 1;
                for (int i = 0; i < 3000; i++) @(posedge i_clk);
                out_stall <= 0;
                hold_off = 0;
            end else begin
                run = $urandom_range(0, 3);
                case (run)
                    0:       out_stall <= 1;
                    default: out_stall <= 0;
                endcase
                repeat ($urandom_range(0, 6)) @(posedge i_clk);
            end
        end
    end

    // wait until every expected result has come, plus latency margin
    task automatic drain();
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // one register write; the write enable is dropped again before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 0;
        @(posedge i_clk);
    endtask

    // offer one transaction and hold it until accepted
    task automatic send_lookup(logic [NUMBER_BITS-1:0] num, logic [PICK_BITS-1:0] pick);
        in_valid <= 1;
        in_item.number      <= num;
        in_item.random_pick <= pick;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic idle_gap();
        in_valid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge i_clk);
    endtask

    // random lookups: small key pool for reuse, some wide numbers
    task automatic random_phase(int count);
        int burst;
        logic [NUMBER_BITS-1:0] num;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) num = NUMBER_BITS'($urandom);
            else num = NUMBER_BITS'($urandom_range(0, 24));
            send_lookup(num, PICK_BITS'($urandom));
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) == 0) idle_gap();
            end else begin
                burst--;
            end
        end
        in_valid <= 0;
    endtask

    initial begin
        hold_off = 0;
        sent     = 0;
        i_rst_n  = 0;
        in_valid = 0;
        in_item  = '0;
        cfg_we   = 0;
        cfg_idx  = REG_POLICY;
        cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes, zero, saturating trajectories, reuse
        send_lookup('0, '0);
        send_lookup(20'd1, 16'hFFFF);
        send_lookup({NUMBER_BITS{1'b1}}, 16'hFFFF);
        send_lookup(20'd27, 16'h5555);
        send_lookup(20'hAAAAA, 16'hAAAA);
        send_lookup(20'h55555, 16'h0001);
        send_lookup('0, '0);
        send_lookup(20'd27, '0);
        send_lookup({NUMBER_BITS{1'b1}}, '0);
        in_valid <= 0;
        drain();

        // each policy at the smallest capacities and with lowering below count
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_POLICY, CFG_DATA_W'(p));
            write_reg(REG_CAPACITY, CFG_DATA_W'(p % 3));
            for (int k = 0; k < 3; k++) send_lookup(NUMBER_BITS'(k + 2), PICK_BITS'(k * 7));
            in_valid <= 0;
            drain();
        end

        // random phases over policies and capacities incl. out-of-range ones
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_POLICY, CFG_DATA_W'(ph % 5));
            case (ph % 4)
                0: write_reg(REG_CAPACITY, 5'd16);
                1: write_reg(REG_CAPACITY, 5'd31);
                2: write_reg(REG_CAPACITY, 5'd1);
                default: write_reg(REG_CAPACITY, CFG_DATA_W'($urandom_range(2, 15)));
            endcase
            if (ph == 4) hold_off = 1;
            random_phase(80);
            drain();
        end

        $display("Sent %0d lookups: %0d hits, %0d misses over all policies.",
                 sent, hits, misses);
        $display("Zero, small and out-of-range capacities, field extremes and a long "
                 , "output hold-off were covered.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
